@@ rtl/prd_pkg.sv @@
// Shared types and constants for the phase residue detector.
// Used by every module of the block but prd_ram; depends on nothing.
`default_nettype none

package prd_pkg;

    // Fixed field widths
    localparam int ROW_BITS      = 12;
    localparam int COL_OUT_BITS  = 12;
    localparam int FLAG_BITS     = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 13;
    localparam int LW_BITS       = 13;
    localparam int XPOS_BITS     = 12;

    localparam logic [ROW_BITS-1:0] ROW_MAX = '1;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LINE_WIDTH = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_START    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_END      = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLUS_MASK  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MINUS_MASK = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_GUIDE_MASK = 3'd5;

    // Configuration reset values
    localparam logic [LW_BITS-1:0]   RST_LINE_WIDTH = 13'd4096;
    localparam logic [XPOS_BITS-1:0] RST_X_START    = 12'd0;
    localparam logic [XPOS_BITS-1:0] RST_X_END      = 12'd4095;
    localparam logic [FLAG_BITS-1:0] RST_PLUS_MASK  = 8'd1;
    localparam logic [FLAG_BITS-1:0] RST_MINUS_MASK = 8'd2;
    localparam logic [FLAG_BITS-1:0] RST_GUIDE_MASK = 8'd4;

    // Charge codes
    localparam logic signed [1:0] CHG_NONE = 2'sb00;
    localparam logic signed [1:0] CHG_POS  = 2'sb01;
    localparam logic signed [1:0] CHG_NEG  = 2'sb11;

    // Per-pixel control that travels from the scan stage to the loop stage
    typedef struct packed {
        logic                    frame;    // pixel restarts the frame
        logic                    has_res;  // a loop closes on this pixel
        logic                    win;      // corner column in x_start .. x_end - 2
        logic [ROW_BITS-1:0]     row;      // corner row
        logic [COL_OUT_BITS-1:0] col;      // corner column, truncated
    } t_s1_ctl;

endpackage

`default_nettype wire

@@ rtl/phase_residue_detector.sv @@
// Top level of the phase residue detector: config registers, line buffer,
// scan and loop stages. Depends on prd_pkg, prd_ram, prd_scan, prd_loop.
//
// Usage: wrapped phase pixels enter in raster order on the input channel
// (i_in_valid / o_in_ready), each with its flag byte and a frame_start bit on
// the first pixel of a region. From row 1, column 1 on, every pixel closes the
// 2x2 loop whose top-left corner is one row up and one column left, and one
// word leaves on the output channel (o_out_valid / i_out_ready) with the
// corner position, the updated corner flag, the charge and the running counts.
// Pixels in row 0 or column 0 produce no word.
// An accepted pixel is held in the loop-stage registers, then its word in the
// output register. Throughput: one pixel per cycle while the output is not
// stalled; each pixel does one read and one write of the single line-buffer
// RAM (previous row's phase and flag, one entry per column).
// Stall: the output register holds its word while i_out_ready is low;
// o_in_ready drops once the loop stage holds a pixel that has a word to give.
// Reset: synchronous, active low; clears position, counts, pipeline valids
// and loads the register defaults. The line buffer is not cleared: row 0 of
// a frame fills it before any value read from it is used.
// Configuration is written through i_cfg_wr_en / i_cfg_index / i_cfg_wr_data
// while the block is idle, a rule for the user; the block does not enforce it.
`default_nettype none

module phase_residue_detector #(
    parameter int MAX_WIDTH  = 4096,
    parameter int PHASE_BITS = 16,
    parameter int COUNT_BITS = 24
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // configuration
    input  wire                                  i_cfg_wr_en,
    input  wire  [prd_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  wire  [prd_pkg::CFG_DATA_BITS-1:0]    i_cfg_wr_data,
    // input channel
    input  wire                                  i_in_valid,
    output logic                                 o_in_ready,
    input  wire  signed [PHASE_BITS-1:0]         i_phase,
    input  wire  [prd_pkg::FLAG_BITS-1:0]        i_flag_in,
    input  wire                                  i_frame_start,
    // output channel
    output logic                                 o_out_valid,
    input  wire                                  i_out_ready,
    output logic [prd_pkg::ROW_BITS-1:0]         o_corner_row,
    output logic [prd_pkg::COL_OUT_BITS-1:0]     o_corner_col,
    output logic [prd_pkg::FLAG_BITS-1:0]        o_flag_out,
    output logic signed [1:0]                    o_charge,
    output logic [COUNT_BITS-1:0]                o_plus_count,
    output logic [COUNT_BITS-1:0]                o_minus_count
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int FB = prd_pkg::FLAG_BITS;
    localparam int MW = PHASE_BITS + FB;

    // Configuration registers
    logic [prd_pkg::LW_BITS-1:0]   r_line_width;
    logic [prd_pkg::XPOS_BITS-1:0] r_x_start, r_x_end;
    logic [FB-1:0]                 r_plus_mask, r_minus_mask, r_guide_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= prd_pkg::RST_LINE_WIDTH;
            r_x_start    <= prd_pkg::RST_X_START;
            r_x_end      <= prd_pkg::RST_X_END;
            r_plus_mask  <= prd_pkg::RST_PLUS_MASK;
            r_minus_mask <= prd_pkg::RST_MINUS_MASK;
            r_guide_mask <= prd_pkg::RST_GUIDE_MASK;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                prd_pkg::CFG_LINE_WIDTH: r_line_width <= i_cfg_wr_data;
                prd_pkg::CFG_X_START:    r_x_start    <= i_cfg_wr_data[prd_pkg::XPOS_BITS-1:0];
                prd_pkg::CFG_X_END:      r_x_end      <= i_cfg_wr_data[prd_pkg::XPOS_BITS-1:0];
                prd_pkg::CFG_PLUS_MASK:  r_plus_mask  <= i_cfg_wr_data[FB-1:0];
                prd_pkg::CFG_MINUS_MASK: r_minus_mask <= i_cfg_wr_data[FB-1:0];
                prd_pkg::CFG_GUIDE_MASK: r_guide_mask <= i_cfg_wr_data[FB-1:0];
                default: ;
            endcase
        end
    end

    // Handshake and loop-stage registers
    logic                    in_accept, s1_adv;
    logic [CW-1:0]           scan_col;
    prd_pkg::t_s1_ctl        scan_ctl;

    logic                    r_s1_valid;
    prd_pkg::t_s1_ctl        r_s1_ctl;
    logic [CW-1:0]           r_s1_col;
    logic signed [PHASE_BITS-1:0] r_s1_phase;
    logic [FB-1:0]           r_s1_flag;
    logic [MW-1:0]           ram_rdata;

    assign s1_adv     = r_s1_valid && (!r_s1_ctl.has_res || !o_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    prd_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_frame_start (i_frame_start),
        .i_line_width  (r_line_width),
        .i_x_start     (r_x_start),
        .i_x_end       (r_x_end),
        .o_col         (scan_col),
        .o_ctl         (scan_ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_ctl   <= scan_ctl;
            r_s1_col   <= scan_col;
            r_s1_phase <= i_phase;
            r_s1_flag  <= i_flag_in;
        end
    end

    // Line buffer: read the column above at accept, overwrite it with this
    // pixel when the loop stage retires it
    prd_ram #(
        .WIDTH (MW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_col),
        .i_wdata ({r_s1_phase, r_s1_flag}),
        .i_re    (in_accept),
        .i_raddr (scan_col),
        .o_rdata (ram_rdata)
    );

    prd_loop #(
        .PHASE_BITS (PHASE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_loop (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (s1_adv),
        .i_ctl         (r_s1_ctl),
        .i_cur_phase   (r_s1_phase),
        .i_up_phase    ($signed(ram_rdata[MW-1:FB])),
        .i_up_flag     (ram_rdata[FB-1:0]),
        .i_plus_mask   (r_plus_mask),
        .i_minus_mask  (r_minus_mask),
        .i_guide_mask  (r_guide_mask),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_corner_row  (o_corner_row),
        .o_corner_col  (o_corner_col),
        .o_flag_out    (o_flag_out),
        .o_charge      (o_charge),
        .o_plus_count  (o_plus_count),
        .o_minus_count (o_minus_count)
    );

endmodule

`default_nettype wire

@@ rtl/prd_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read.
// Standalone; no package dependency.
`default_nettype none

module prd_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/prd_scan.sv @@
// Raster position tracker: column/row counters, row wrap and counting window.
// Depends on prd_pkg.
`default_nettype none

module prd_scan #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_accept,
    input  wire                                 i_frame_start,
    input  wire  [prd_pkg::LW_BITS-1:0]         i_line_width,
    input  wire  [prd_pkg::XPOS_BITS-1:0]       i_x_start,
    input  wire  [prd_pkg::XPOS_BITS-1:0]       i_x_end,
    output logic [$clog2(MAX_WIDTH)-1:0]        o_col,
    output prd_pkg::t_s1_ctl                    o_ctl
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int MWB = $clog2(MAX_WIDTH + 1);
    localparam int WB  = ((MWB > prd_pkg::LW_BITS) ? MWB : prd_pkg::LW_BITS) + 1;

    logic [CW-1:0]                r_col_pos;
    logic [prd_pkg::ROW_BITS-1:0] r_row_pos;
    logic [CW-1:0]                n_col_pos;
    logic [prd_pkg::ROW_BITS-1:0] n_row_pos;

    logic [WB-1:0]                lw, w, wm1, xe_raw, xe, xs, colq_w, c_w, cc_w;
    logic [CW-1:0]                colq, c;
    logic [prd_pkg::ROW_BITS-1:0] rowq, r, r_inc;
    logic                         last;

    // Clamp the width and the window end
    always_comb begin
        lw = WB'(i_line_width);
        if (lw < WB'(2)) begin
            w = WB'(2);
        end else if (lw > WB'(MAX_WIDTH)) begin
            w = WB'(MAX_WIDTH);
        end else begin
            w = lw;
        end
        wm1    = w - WB'(1);
        xe_raw = WB'(i_x_end);
        xe     = (xe_raw < wm1) ? xe_raw : wm1;
        xs     = WB'(i_x_start);
    end

    // Position of the incoming pixel
    always_comb begin
        colq   = i_frame_start ? '0 : r_col_pos;
        rowq   = i_frame_start ? '0 : r_row_pos;
        colq_w = WB'(colq);
        if (colq_w >= w) begin
            c = '0;
            r = (rowq == prd_pkg::ROW_MAX) ? rowq : rowq + 1'b1;
        end else begin
            c = colq;
            r = rowq;
        end
        c_w   = WB'(c);
        cc_w  = c_w - WB'(1);
        r_inc = (r == prd_pkg::ROW_MAX) ? r : r + 1'b1;
        last  = (c_w + WB'(1)) >= w;
        n_col_pos = last ? '0 : c + 1'b1;
        n_row_pos = last ? r_inc : r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_pos <= '0;
            r_row_pos <= '0;
        end else if (i_accept) begin
            r_col_pos <= n_col_pos;
            r_row_pos <= n_row_pos;
        end
    end

    // Control word for the loop stage
    always_comb begin
        o_col         = c;
        o_ctl.frame   = i_frame_start;
        o_ctl.has_res = (r != '0) && (c != '0);
        o_ctl.win     = (cc_w >= xs) && ((cc_w + WB'(2)) <= xe);
        o_ctl.row     = r - 1'b1;
        o_ctl.col     = prd_pkg::COL_OUT_BITS'(cc_w);
    end

endmodule

`default_nettype wire

@@ rtl/prd_loop.sv @@
// Loop stage: 2x2 charge from line-buffer data, flag update, running counts,
// and the output register. Depends on prd_pkg.
`default_nettype none

module prd_loop #(
    parameter int PHASE_BITS = 16,
    parameter int COUNT_BITS = 24
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_adv,
    input  prd_pkg::t_s1_ctl                    i_ctl,
    input  wire  signed [PHASE_BITS-1:0]        i_cur_phase,
    input  wire  signed [PHASE_BITS-1:0]        i_up_phase,
    input  wire  [prd_pkg::FLAG_BITS-1:0]       i_up_flag,
    input  wire  [prd_pkg::FLAG_BITS-1:0]       i_plus_mask,
    input  wire  [prd_pkg::FLAG_BITS-1:0]       i_minus_mask,
    input  wire  [prd_pkg::FLAG_BITS-1:0]       i_guide_mask,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic [prd_pkg::ROW_BITS-1:0]        o_corner_row,
    output logic [prd_pkg::COL_OUT_BITS-1:0]    o_corner_col,
    output logic [prd_pkg::FLAG_BITS-1:0]       o_flag_out,
    output logic signed [1:0]                   o_charge,
    output logic [COUNT_BITS-1:0]               o_plus_count,
    output logic [COUNT_BITS-1:0]               o_minus_count
);

    localparam int PB = PHASE_BITS;
    localparam logic signed [PB:0] HALF_P = {2'b01, {(PB-1){1'b0}}};
    localparam logic signed [PB:0] HALF_N = {2'b11, {(PB-1){1'b0}}};

    // Wrapped difference a - b rounded to whole cycles, halves away from zero
    function automatic logic signed [2:0] cyc(input logic signed [PB-1:0] a,
                                              input logic signed [PB-1:0] b);
        logic signed [PB:0] d;
        d = {a[PB-1], a} - {b[PB-1], b};
        if (d >= HALF_P) begin
            return 3'sd1;
        end else if (d <= HALF_N) begin
            return -3'sd1;
        end
        return 3'sd0;
    endfunction

    logic signed [PB-1:0]          r_upl_phase, r_left_phase;
    logic [prd_pkg::FLAG_BITS-1:0] r_upl_flag;
    logic [COUNT_BITS-1:0]         r_plus, r_minus, n_plus, n_minus;
    logic [COUNT_BITS-1:0]         plus_base, minus_base;
    logic signed [2:0]             d0, d1, d2, d3;
    logic signed [3:0]             k;
    logic                          pos, neg;
    logic [prd_pkg::FLAG_BITS-1:0] n_flag;
    logic signed [1:0]             n_charge;

    // Loop sum: up - upleft, cur - up, left - cur, upleft - left
    always_comb begin
        d0 = cyc(i_up_phase, r_upl_phase);
        d1 = cyc(i_cur_phase, i_up_phase);
        d2 = cyc(r_left_phase, i_cur_phase);
        d3 = cyc(r_upl_phase, r_left_phase);
        k  = {d0[2], d0} + {d1[2], d1} + {d2[2], d2} + {d3[2], d3};
        pos = i_ctl.has_res && i_ctl.win && !k[3] && (k != '0);
        neg = i_ctl.has_res && i_ctl.win && k[3];
    end

    // Flag, charge and saturating counts
    always_comb begin
        plus_base  = i_ctl.frame ? '0 : r_plus;
        minus_base = i_ctl.frame ? '0 : r_minus;
        n_plus     = (pos && !(&plus_base)) ? plus_base + 1'b1 : plus_base;
        n_minus    = (neg && !(&minus_base)) ? minus_base + 1'b1 : minus_base;
        if (pos) begin
            n_flag   = (r_upl_flag | i_plus_mask) & ~i_guide_mask;
            n_charge = prd_pkg::CHG_POS;
        end else if (neg) begin
            n_flag   = (r_upl_flag | i_minus_mask) & ~i_guide_mask;
            n_charge = prd_pkg::CHG_NEG;
        end else begin
            n_flag   = r_upl_flag;
            n_charge = prd_pkg::CHG_NONE;
        end
    end

    // Neighbor history: previous pixel and the line-buffer word above it
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_upl_phase  <= i_up_phase;
            r_upl_flag   <= i_up_flag;
            r_left_phase <= i_cur_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plus  <= '0;
            r_minus <= '0;
        end else if (i_adv) begin
            r_plus  <= n_plus;
            r_minus <= n_minus;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_adv && i_ctl.has_res) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_ctl.has_res) begin
            o_corner_row  <= i_ctl.row;
            o_corner_col  <= i_ctl.col;
            o_flag_out    <= n_flag;
            o_charge      <= n_charge;
            o_plus_count  <= n_plus;
            o_minus_count <= n_minus;
        end
    end

endmodule

`default_nettype wire

@@ rtl/prd_checker.sv @@
// Port-level checker for the phase residue detector, bound to the top level.
// Depends on prd_pkg.
`default_nettype none

module prd_checker #(
    parameter int COUNT_BITS = 24
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          o_out_valid,
    input  wire                          i_out_ready,
    input  wire  [prd_pkg::ROW_BITS-1:0] o_corner_row,
    input  wire  signed [1:0]            o_charge,
    input  wire  [COUNT_BITS-1:0]        o_plus_count,
    input  wire  [COUNT_BITS-1:0]        o_minus_count
);

    // A reset cycle leaves no word pending
    a_rst_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid after reset");

    // Stalled word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_corner_row) && $stable(o_charge))
        else $error("stalled output word changed");

    // Charge is one of the three legal codes
    a_charge_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_charge == prd_pkg::CHG_NONE || o_charge == prd_pkg::CHG_POS ||
                         o_charge == prd_pkg::CHG_NEG))
        else $error("illegal charge code");

    // A positive loop is included in the plus count
    a_plus_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_charge == prd_pkg::CHG_POS |-> o_plus_count != '0)
        else $error("positive loop with zero plus count");

    // A negative loop is included in the minus count
    a_minus_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_charge == prd_pkg::CHG_NEG |-> o_minus_count != '0)
        else $error("negative loop with zero minus count");

endmodule

bind phase_residue_detector prd_checker #(.COUNT_BITS(COUNT_BITS)) u_prd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_corner_row  (o_corner_row),
    .o_charge      (o_charge),
    .o_plus_count  (o_plus_count),
    .o_minus_count (o_minus_count)
);

`default_nettype wire
